@@ design/mbct_pkg.sv @@
// Shared types and codes for the block cache tag engine.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package mbct_pkg;

	// action codes on the request port
	localparam logic [2:0] ACT_READ        = 3'd0;
	localparam logic [2:0] ACT_WRITE       = 3'd1;
	localparam logic [2:0] ACT_FLUSH       = 3'd2;
	localparam logic [2:0] ACT_CLOSE       = 3'd3;
	localparam logic [2:0] ACT_CLOSE_FLUSH = 3'd4;

	// result kinds
	localparam logic [1:0] KIND_ACCESS    = 2'd0;
	localparam logic [1:0] KIND_WRITEBACK = 2'd1;
	localparam logic [1:0] KIND_DONE      = 2'd2;

	// capacity register
	localparam int         CAP_W     = 5;
	localparam logic [4:0] CAP_RESET = 5'd16;

	// result slot field width
	localparam int SLOT_OUT_W = 4;

	// controller to datapath commands
	typedef struct packed {
		logic load;       // capture block number of an accepted access
		logic access;     // tag compare, replacement and state update
		logic is_write;   // access is a write, set the dirty mark
		logic walk_start; // rewind the flush slot counter
		logic walk;       // visit one slot of a flush
		logic finish;     // emit the done marker
		logic drop;       // invalidate every entry with the done marker
	} mbct_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic walk_last;  // flush counter sits on the highest slot
	} mbct_status_t;

endpackage

`default_nettype wire

@@ design/mbct_ctrl.sv @@
// Sequencing state machine of the block cache tag engine.
// Depends on mbct_pkg for action codes and the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module mbct_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [2:0]          action,
	input  wire mbct_pkg::mbct_status_t status,
	output mbct_pkg::mbct_cmd_t      cmd,
	output logic                     busy
);
	import mbct_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_ACCESS = 4'b0010,
		S_WALK   = 4'b0100,
		S_DONE   = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   write_q, write_d;
	logic   close_q, close_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		write_d = write_q;
		close_d = close_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (action)
						ACT_READ, ACT_WRITE: begin
							cmd.load = 1'b1;
							write_d  = (action == ACT_WRITE);
							state_d  = S_ACCESS;
						end
						ACT_FLUSH: begin
							cmd.walk_start = 1'b1;
							close_d        = 1'b0;
							state_d        = S_WALK;
						end
						ACT_CLOSE: begin
							close_d = 1'b1;
							state_d = S_DONE;
						end
						ACT_CLOSE_FLUSH: begin
							cmd.walk_start = 1'b1;
							close_d        = 1'b1;
							state_d        = S_WALK;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_ACCESS: begin
				cmd.access   = 1'b1;
				cmd.is_write = write_q;
				state_d      = S_IDLE;
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (status.walk_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				cmd.finish = 1'b1;
				cmd.drop   = close_q;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			write_q <= 1'b0;
			close_q <= 1'b0;
		end else begin
			state_q <= state_d;
			write_q <= write_d;
			close_q <= close_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

@@ design/mbct_datapath.sv @@
// Tag store, valid and dirty marks, replacement logic and result registers.
// Depends on mbct_pkg; driven by commands from mbct_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module mbct_datapath #(
	parameter int NUM_SLOTS  = 16,
	parameter int BLOCK_BITS = 20
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire mbct_pkg::mbct_cmd_t                cmd,
	output mbct_pkg::mbct_status_t                  status,
	input  wire logic [BLOCK_BITS-1:0]              block_number,
	input  wire logic                               cfg_we,
	input  wire logic [mbct_pkg::CAP_W-1:0]         cfg_wdata,
	output logic                                    strobe,
	output logic [1:0]                              kind,
	output logic                                    hit,
	output logic [mbct_pkg::SLOT_OUT_W-1:0]         slot,
	output logic                                    evicted,
	output logic [BLOCK_BITS-1:0]                   victim_block,
	output logic                                    victim_dirty,
	output logic                                    last
);
	import mbct_pkg::*;

	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int OCC_W  = $clog2(NUM_SLOTS + 1);
	localparam int CW     = (OCC_W > CAP_W) ? OCC_W : CAP_W;

	// stored state
	logic [BLOCK_BITS-1:0] tag_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]  valid_q;
	logic [NUM_SLOTS-1:0]  dirty_q;
	logic [SLOT_W-1:0]     recent_q;
	logic [OCC_W-1:0]      occ_q;
	logic [CAP_W-1:0]      cap_q;
	logic [BLOCK_BITS-1:0] blk_q;
	logic [SLOT_W-1:0]     idx_q;

	// result registers
	logic                  strobe_q;
	logic [1:0]            kind_q;
	logic                  hit_q;
	logic [SLOT_OUT_W-1:0] slot_q;
	logic                  evicted_q;
	logic [BLOCK_BITS-1:0] victim_q;
	logic                  vdirty_q;
	logic                  last_q;

	// associative compare and free slot search, lowest slot wins
	logic [NUM_SLOTS-1:0] match;
	logic                 found;
	logic [SLOT_W-1:0]    hit_idx;
	logic                 have_free;
	logic [SLOT_W-1:0]    free_idx;

	always_comb begin
		hit_idx   = '0;
		free_idx  = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			match[i] = valid_q[i] && (tag_q[i] == blk_q);
			if (match[i]) begin
				hit_idx = SLOT_W'(i);
			end
			if (!valid_q[i]) begin
				free_idx = SLOT_W'(i);
			end
		end
		found     = |match;
		have_free = ~&valid_q;
	end

	// replacement decision
	logic [CW-1:0]     cap_ext, cap_eff, occ_ext;
	logic              full;
	logic              recent_valid;
	logic              use_recent;
	logic              evict;
	logic [SLOT_W-1:0] slot_sel;
	logic              occ_room;

	always_comb begin
		cap_ext = CW'(cap_q);
		occ_ext = CW'(occ_q);
		priority if (cap_ext == '0) begin
			cap_eff = CW'(1);
		end else if (cap_ext > CW'(NUM_SLOTS)) begin
			cap_eff = CW'(NUM_SLOTS);
		end else begin
			cap_eff = cap_ext;
		end
		full         = (occ_ext >= cap_eff);
		recent_valid = valid_q[recent_q];
		use_recent   = (full && recent_valid) || !have_free;
		evict        = !found && use_recent && recent_valid;
		if (found) begin
			slot_sel = hit_idx;
		end else if (use_recent) begin
			slot_sel = recent_q;
		end else begin
			slot_sel = free_idx;
		end
		occ_room = (occ_q < OCC_W'(NUM_SLOTS));
	end

	assign status.walk_last = (idx_q == SLOT_W'(NUM_SLOTS - 1));

	// access block number capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			blk_q <= block_number;
		end
	end

	// tag store, written on a miss
	always_ff @(posedge clk) begin
		if (cmd.access && !found) begin
			tag_q[slot_sel] <= blk_q;
		end
	end

	// marks, occupancy, recent slot, flush counter and capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			dirty_q  <= '0;
			recent_q <= '0;
			occ_q    <= '0;
			idx_q    <= '0;
			cap_q    <= CAP_RESET;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (cmd.access) begin
				if (!found) begin
					valid_q[slot_sel] <= 1'b1;
					if (!evict && occ_room) begin
						occ_q <= occ_q + OCC_W'(1);
					end
				end
				dirty_q[slot_sel] <= cmd.is_write || (found && dirty_q[slot_sel]);
				recent_q          <= slot_sel;
			end
			if (cmd.walk_start) begin
				idx_q <= '0;
			end else if (cmd.walk) begin
				dirty_q[idx_q] <= 1'b0;
				idx_q          <= idx_q + SLOT_W'(1);
			end
			if (cmd.finish && cmd.drop) begin
				valid_q  <= '0;
				dirty_q  <= '0;
				occ_q    <= '0;
				recent_q <= '0;
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.access || cmd.finish
				|| (cmd.walk && valid_q[idx_q] && dirty_q[idx_q]);
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.access) begin
			kind_q    <= KIND_ACCESS;
			hit_q     <= found;
			slot_q    <= SLOT_OUT_W'(slot_sel);
			evicted_q <= evict;
			victim_q  <= evict ? tag_q[recent_q] : '0;
			vdirty_q  <= evict && dirty_q[recent_q];
			last_q    <= 1'b1;
		end else if (cmd.walk) begin
			kind_q    <= KIND_WRITEBACK;
			hit_q     <= 1'b0;
			slot_q    <= SLOT_OUT_W'(idx_q);
			evicted_q <= 1'b0;
			victim_q  <= tag_q[idx_q];
			vdirty_q  <= 1'b1;
			last_q    <= 1'b0;
		end else if (cmd.finish) begin
			kind_q    <= KIND_DONE;
			hit_q     <= 1'b0;
			slot_q    <= '0;
			evicted_q <= 1'b0;
			victim_q  <= '0;
			vdirty_q  <= 1'b0;
			last_q    <= 1'b1;
		end
	end

	assign strobe       = strobe_q;
	assign kind         = kind_q;
	assign hit          = hit_q;
	assign slot         = slot_q;
	assign evicted      = evicted_q;
	assign victim_block = victim_q;
	assign victim_dirty = vdirty_q;
	assign last         = last_q;

endmodule

`default_nettype wire

@@ design/mru_block_cache_tags_top.sv @@
// Top level of the write-back block cache tag engine with MRU replacement.
// Depends on mbct_pkg, mbct_ctrl and mbct_datapath.
`timescale 1ns / 1ps
`default_nettype none

// A request is taken when start is high and busy is low. A read or write
// keeps busy high in its access state, in which all tags are compared in
// parallel and the slot, marks and occupancy are updated; its result shows
// with strobe in the next cycle, when a new request can already be taken.
// A flush walks the slots one slot per cycle, emits a writeback transfer
// for each dirty slot, then the done marker. A close without flush emits
// only the done marker; both closes invalidate every entry with it.
// Every result is held for exactly one cycle; the receiver cannot stall.
// Action codes 5 to 7 are taken and ignored.
// Write capacity only while idle.
module mru_block_cache_tags_top #(
	parameter int NUM_SLOTS  = 16,
	parameter int BLOCK_BITS = 20
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [2:0]                  action,
	input  wire logic [BLOCK_BITS-1:0]       block_number,
	input  wire logic                        cfg_we,
	input  wire logic [mbct_pkg::CAP_W-1:0]  cfg_wdata,
	output logic                             strobe,
	output logic [1:0]                       kind,
	output logic                             hit,
	output logic [mbct_pkg::SLOT_OUT_W-1:0]  slot,
	output logic                             evicted,
	output logic [BLOCK_BITS-1:0]            victim_block,
	output logic                             victim_dirty,
	output logic                             last
);
	import mbct_pkg::*;

	mbct_cmd_t    cmd;
	mbct_status_t status;

	// sequencing
	mbct_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// tags, marks and results
	mbct_datapath #(
		.NUM_SLOTS  (NUM_SLOTS),
		.BLOCK_BITS (BLOCK_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.block_number (block_number),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.strobe       (strobe),
		.kind         (kind),
		.hit          (hit),
		.slot         (slot),
		.evicted      (evicted),
		.victim_block (victim_block),
		.victim_dirty (victim_dirty),
		.last         (last)
	);

	// an accepted read or write gives its access result, registered after the access state
	a_access_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (action == ACT_READ || action == ACT_WRITE))
		|=> ##1 (strobe && kind == KIND_ACCESS && last))
		else $error("access result missing");

	// busy only rises after an accepted request
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy without request");

	// a writeback transfer names a dirty block and never ends the item
	a_writeback_form: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && kind == KIND_WRITEBACK) |-> (victim_dirty && !last && !hit))
		else $error("malformed writeback");

	// eviction happens only on a miss
	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && evicted) |-> (!hit && kind == KIND_ACCESS))
		else $error("eviction on a hit");

endmodule

`default_nettype wire
